// ===== rtl/core/rhc_pkg.sv =====
// rhc_pkg: widths, hue sector constants and the side-band record shared by
// the RGB to HSL converter. No dependencies.
package rhc_pkg;

  localparam int CH_W  = 8;
  localparam int HUE_W = 9;
  localparam int SAT_W = 16;
  localparam int SUM_W = 9;

  // Restoring divider shape, sized for the saturation quotient (up to 65536).
  // The hue quotient (0..60) runs through the same shape.
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 9;
  localparam int DIV_Q_W   = 17;
  localparam int HUE_Q_W   = 6;

  // Sector start angles in degrees
  localparam logic [HUE_W-1:0] HUE_RED  = 9'd0;
  localparam logic [HUE_W-1:0] HUE_YEL  = 9'd60;
  localparam logic [HUE_W-1:0] HUE_GRN  = 9'd120;
  localparam logic [HUE_W-1:0] HUE_CYN  = 9'd180;
  localparam logic [HUE_W-1:0] HUE_BLU  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_MAG  = 9'd300;
  localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;

  localparam logic [SUM_W-1:0] SUM_MID  = 9'd255;
  localparam logic [SUM_W-1:0] SUM_FULL = 9'd510;

  // 2 * 60: numerator scale for round-half-up of 60*d/chroma
  localparam logic [14:0] HUE_SCALE = 15'd120;

  typedef struct packed {
    logic             gray;
    logic [HUE_W-1:0] base;
    logic [SUM_W-1:0] sum;
  } side_t;

endpackage

// ===== rtl/core/rgb_to_hsl_convert.sv =====
// rgb_to_hsl_convert: pipelined RGB to HSL pixel converter, top level.
// Depends on rhc_pkg and rhc_div.
//
// Usage:
//   Drive red/green/blue and pulse start. A request is taken at each rising
//   edge with start high and busy low; busy is never raised, so one pixel
//   can be taken every clock cycle.
//   Each request produces one result on hue/saturation/lightness, marked by
//   done for exactly one cycle. Results come out in request order.
//   The pipeline has three front stages (max/min, sector, dividend build),
//   17 stages of the restoring divider (one quotient bit each, sized by the
//   17-bit saturation quotient) and one output register. Throughput is one
//   pixel per cycle.
//   The receiver has no hold-off; the pipeline never stalls.
//   Reset (rst, synchronous) clears every valid bit, dropping requests in
//   flight; done stays low until new results arrive.
//   Grey pixels give hue 0 and saturation 0; lightness is max+min (/510).
module rgb_to_hsl_convert
  import rhc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output logic             done,
  output logic [HUE_W-1:0] hue,
  output logic [SAT_W-1:0] saturation,
  output logic [SUM_W-1:0] lightness
);

  assign busy = 1'b0;

  // ---------------- stage A: channel max / min
  logic [CH_W-1:0] in_max;
  logic [CH_W-1:0] in_min;
  logic [CH_W-1:0] rg_max;
  logic [CH_W-1:0] rg_min;

  assign rg_max = (red > green) ? red : green;
  assign rg_min = (red < green) ? red : green;
  assign in_max = (rg_max > blue) ? rg_max : blue;
  assign in_min = (rg_min < blue) ? rg_min : blue;

  logic            a_vld;
  logic [CH_W-1:0] a_red;
  logic [CH_W-1:0] a_green;
  logic [CH_W-1:0] a_blue;
  logic [CH_W-1:0] a_max;
  logic [CH_W-1:0] a_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_red   <= red;
    a_green <= green;
    a_blue  <= blue;
    a_max   <= in_max;
    a_min   <= in_min;
  end

  // ---------------- stage B: chroma, sum, sector
  // Falling half of a sector is folded into the rising half of the one
  // before it: base - 60*d/c == (base-60) + 60*(c-d)/c.
  logic [CH_W-1:0]  chroma_c;
  logic [SUM_W-1:0] sum_c;
  logic [HUE_W-1:0] base_c;
  logic [CH_W-1:0]  d_c;

  assign chroma_c = a_max - a_min;
  assign sum_c    = {1'b0, a_max} + {1'b0, a_min};

  always_comb begin
    if (a_max == a_red) begin
      if (a_green >= a_blue) begin
        base_c = HUE_RED;
        d_c    = a_green - a_blue;
      end else begin
        base_c = HUE_MAG;
        d_c    = chroma_c - (a_blue - a_green);
      end
    end else if (a_max == a_green) begin
      if (a_blue >= a_red) begin
        base_c = HUE_GRN;
        d_c    = a_blue - a_red;
      end else begin
        base_c = HUE_YEL;
        d_c    = chroma_c - (a_red - a_blue);
      end
    end else begin
      if (a_red >= a_green) begin
        base_c = HUE_BLU;
        d_c    = a_red - a_green;
      end else begin
        base_c = HUE_CYN;
        d_c    = chroma_c - (a_green - a_red);
      end
    end
  end

  logic             b_vld;
  logic [CH_W-1:0]  b_chroma;
  logic [SUM_W-1:0] b_sum;
  logic [HUE_W-1:0] b_base;
  logic [CH_W-1:0]  b_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_chroma <= chroma_c;
    b_sum    <= sum_c;
    b_base   <= base_c;
    b_d      <= d_c;
  end

  // ---------------- stage C: dividends and divisors
  // hue offset = floor((120*d + c) / (2c)), saturation = floor((c*2^17 + den) / (2den))
  logic [CH_W-1:0]      den_c;
  logic [14:0]          hnum_c;
  logic [DIV_NUM_W-1:0] snum_c;

  assign den_c  = (b_sum <= SUM_MID) ? b_sum[CH_W-1:0] : CH_W'(SUM_FULL - b_sum);
  assign hnum_c = 15'(b_d) * HUE_SCALE + 15'(b_chroma);
  assign snum_c = {b_chroma, 17'b0} + DIV_NUM_W'(den_c);

  logic                 c_vld;
  logic [DIV_NUM_W-1:0] c_hnum;
  logic [DIV_DEN_W-1:0] c_hden;
  logic [DIV_NUM_W-1:0] c_snum;
  logic [DIV_DEN_W-1:0] c_sden;
  side_t                c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_hnum      <= DIV_NUM_W'(hnum_c);
    c_hden      <= {b_chroma, 1'b0};
    c_snum      <= snum_c;
    c_sden      <= {den_c, 1'b0};
    c_side.gray <= (b_chroma == '0);
    c_side.base <= b_base;
    c_side.sum  <= b_sum;
  end

  // ---------------- divider stages
  logic               div_vld;
  logic               sat_vld;
  logic [DIV_Q_W-1:0] hue_q;
  logic [DIV_Q_W-1:0] sat_q;

  rhc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_hue_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (c_vld),
    .num     (c_hnum),
    .den     (c_hden),
    .out_vld (div_vld),
    .quo     (hue_q)
  );

  rhc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_sat_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (c_vld),
    .num     (c_snum),
    .den     (c_sden),
    .out_vld (sat_vld),
    .quo     (sat_q)
  );

  // side data rides alongside the divider
  side_t side_q [1:DIV_Q_W];

  always_ff @(posedge clk) begin
    side_q[1] <= c_side;
    for (int i = 1; i < DIV_Q_W; i++) begin
      side_q[i+1] <= side_q[i];
    end
  end

  // ---------------- output stage
  side_t            d_side;
  logic [HUE_W-1:0] hue_sum;
  logic [HUE_W-1:0] hue_c;
  logic [SAT_W-1:0] sat_c;

  assign d_side  = side_q[DIV_Q_W];
  assign hue_sum = d_side.base + HUE_W'(hue_q[HUE_Q_W-1:0]);

  always_comb begin
    if (d_side.gray) begin
      hue_c = '0;
      sat_c = '0;
    end else begin
      hue_c = (hue_sum >= HUE_WRAP) ? hue_sum - HUE_WRAP : hue_sum;
      sat_c = sat_q[DIV_Q_W-1] ? '1 : sat_q[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    hue        <= hue_c;
    saturation <= sat_c;
    lightness  <= d_side.sum;
  end

  // ---------------- checks
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##21 done)
    else $error("result strobe missing 21 cycles after request");

  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (hue < HUE_WRAP) && (lightness <= SUM_FULL))
    else $error("hue or lightness out of range");

  a_black_white : assert property (@(posedge clk) disable iff (rst)
    (done && (lightness == '0 || lightness == SUM_FULL)) |->
      (hue == '0 && saturation == '0))
    else $error("black or white pixel with nonzero hue or saturation");

  a_div_lockstep : assert property (@(posedge clk) disable iff (rst)
    div_vld == sat_vld)
    else $error("hue and saturation dividers out of step");

endmodule

// ===== rtl/core/rhc_div.sv =====
// rhc_div: pipelined restoring divider, one quotient bit per stage.
// Depends on rhc_pkg for default widths.
module rhc_div
  import rhc_pkg::*;
#(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int Q_W   = DIV_Q_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo
);

  localparam int W = DEN_W + Q_W;

  // num must stay below den * 2**Q_W
  logic             vld [1:Q_W];
  logic [Q_W-1:0]   q   [1:Q_W];
  logic [W-1:0]     rem [1:Q_W-1];
  logic [DEN_W-1:0] dv  [1:Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [W-1:0]     rem_in;
    logic [W-1:0]     trial;
    logic [DEN_W-1:0] dv_in;
    logic [Q_W-1:0]   q_in;
    logic             vld_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = W'(num);
      assign dv_in  = den;
      assign q_in   = '0;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem[k];
      assign dv_in  = dv[k];
      assign q_in   = q[k];
      assign vld_in = vld[k];
    end

    assign trial = W'(dv_in) << (Q_W - 1 - k);
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      q[k+1] <= {q_in[Q_W-2:0], ge};
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? rem_in - trial : rem_in;
        dv[k+1]  <= dv_in;
      end
    end
  end

  assign out_vld = vld[Q_W];
  assign quo     = q[Q_W];

endmodule

// ===== tb/rgb_to_hsl_convert_tb.sv =====
// rgb_to_hsl_convert_tb: self-checking bench for the RGB to HSL converter.
// Drives directed and random pixels with random gaps, predicts hue/saturation/
// lightness in integer math and checks each done strobe in order. Needs rhc_pkg.
`timescale 1ns / 1ps

module rgb_to_hsl_convert_tb;
  import rhc_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SUM_W-1:0] light;
  } hsl_t;

  localparam int RAND_ITEMS = 1750;
  localparam int DRAIN_CYC  = 40;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             done;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [SUM_W-1:0] lightness;

  pixel_t pixel_q[$];   // requests not yet driven
  hsl_t   hsl_due[$];   // predicted results, oldest first
  int     bad_cnt;
  int     sent_cnt;
  bit     req_taken;

  rgb_to_hsl_convert dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  always begin
    #2 clk = ~clk;
  end

  // Exact integer HSL: hue rounded half up, saturation in Q0.16 clipped at 65535
  function automatic hsl_t hsl_of(pixel_t px);
    int unsigned ri, gi, bi, mx, mn, chroma, sum, num, den, hq;
    longint unsigned q;
    hsl_t res;
    ri = px.r;
    gi = px.g;
    bi = px.b;
    mx = (ri > gi) ? ri : gi;
    mx = (mx > bi) ? mx : bi;
    mn = (ri < gi) ? ri : gi;
    mn = (mn < bi) ? mn : bi;
    chroma = mx - mn;
    sum = mx + mn;
    res.hue = '0;
    res.sat = '0;
    res.light = sum[SUM_W-1:0];
    if (chroma != 0) begin
      // sector picked by max channel, red wins ties, then green
      if (mx == ri) begin
        num = (gi >= bi) ? 60 * (gi - bi) : 360 * chroma - 60 * (bi - gi);
      end else if (mx == gi) begin
        num = (bi >= ri) ? 120 * chroma + 60 * (bi - ri) : 120 * chroma - 60 * (ri - bi);
      end else begin
        num = (ri >= gi) ? 240 * chroma + 60 * (ri - gi) : 240 * chroma - 60 * (gi - ri);
      end
      hq = (2 * num + chroma) / (2 * chroma);
      if (hq >= 360) hq = hq - 360;
      res.hue = hq[HUE_W-1:0];
      den = (sum <= 255) ? sum : 510 - sum;
      q = (longint'(chroma) * 131072 + den) / (2 * longint'(den));
      res.sat = (q > 65535) ? 16'hFFFF : q[SAT_W-1:0];
    end
    return res;
  endfunction

  task automatic add_pixel(int r, int g, int b);
    pixel_t px;
    px.r = r[CH_W-1:0];
    px.g = g[CH_W-1:0];
    px.b = b[CH_W-1:0];
    pixel_q.push_back(px);
  endtask

  // Driver: a request stays on the ports until taken
  always @(negedge clk) begin
    pixel_t px;
    if (!rst && (!start || req_taken)) begin
      // no gaps across a long middle stretch
      if (pixel_q.size() > 0 &&
          ((sent_cnt >= 600 && sent_cnt < 1000) || $urandom_range(0, 99) >= 36)) begin
        px = pixel_q.pop_front();
        red <= px.r;
        green <= px.g;
        blue <= px.b;
        start <= 1'b1;
        sent_cnt <= sent_cnt + 1;
      end else begin
        start <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          red <= CH_W'($urandom);
          green <= CH_W'($urandom);
          blue <= CH_W'($urandom);
        end
      end
    end
  end

  // Monitor: check results, then record the request taken at this edge
  always @(posedge clk) begin
    hsl_t want;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (done) begin
        if (hsl_due.size() == 0) begin
          bad_cnt = bad_cnt + 1;
          if (bad_cnt <= 10)
            $display("%0t: result with nothing pending: hue=%0d sat=%0d light=%0d",
                     $realtime, hue, saturation, lightness);
        end else begin
          want = hsl_due.pop_front();
          if (hue !== want.hue || saturation !== want.sat || lightness !== want.light) begin
            bad_cnt = bad_cnt + 1;
            if (bad_cnt <= 10)
              $display("%0t: mismatch: hue %0d/%0d sat %0d/%0d light %0d/%0d (exp/got)",
                       $realtime, want.hue, hue, want.sat, saturation,
                       want.light, lightness);
          end
        end
      end
      req_taken = start && !busy;
      if (req_taken) hsl_due.push_back(hsl_of({red, green, blue}));
    end
  end

  initial begin
    int mode, lo, hi;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    bad_cnt = 0;
    sent_cnt = 0;
    req_taken = 1'b0;

    // black, white, greys
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    // primaries and secondaries (full saturation clips)
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    // hue just under 360 rounds up and wraps; then a red and blue tie at hue 300
    add_pixel(255, 0, 1);
    add_pixel(255, 254, 255);
    // exact half-degree hues round up
    add_pixel(120, 1, 0);
    add_pixel(8, 1, 0);
    // tied maxima in each pairing
    add_pixel(200, 200, 17);
    add_pixel(17, 200, 200);
    add_pixel(200, 17, 200);
    // tiny denominators at both lightness ends
    add_pixel(1, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(255, 254, 254);
    add_pixel(254, 255, 254);
    // green and blue sectors on both sides
    add_pixel(10, 200, 90);
    add_pixel(90, 200, 10);
    add_pixel(90, 10, 200);
    add_pixel(10, 90, 200);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          lo = $urandom_range(0, 255);
          add_pixel(lo, lo, lo);
        end
        1: begin
          // two channels tied
          lo = $urandom_range(0, 255);
          hi = $urandom_range(0, 255);
          case ($urandom_range(0, 2))
            0: add_pixel(lo, lo, hi);
            1: add_pixel(hi, lo, lo);
            default: add_pixel(lo, hi, lo);
          endcase
        end
        2: begin
          // small chroma near a random level
          lo = $urandom_range(0, 252);
          add_pixel(lo + $urandom_range(0, 3), lo + $urandom_range(0, 3),
                    lo + $urandom_range(0, 3));
        end
        3: add_pixel($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
        4: add_pixel($urandom_range(252, 255), $urandom_range(252, 255),
                     $urandom_range(252, 255));
        5: begin
          // one channel at an extreme
          lo = ($urandom_range(0, 1) == 1) ? 255 : 0;
          case ($urandom_range(0, 2))
            0: add_pixel(lo, $urandom_range(0, 255), $urandom_range(0, 255));
            1: add_pixel($urandom_range(0, 255), lo, $urandom_range(0, 255));
            default: add_pixel($urandom_range(0, 255), $urandom_range(0, 255), lo);
          endcase
        end
        default: add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pixel_q.size() != 0 || start) @(negedge clk);
    while (hsl_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (bad_cnt == 0 && hsl_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
